/* rtl/hfub_pkg.sv */
package hfub_pkg;

   // Number of floor slots, one chain cell per slot.
   localparam int NUM_FLOORS = 16;

   localparam int SLOT_W = 4;
   localparam int POS_W  = 32;
   localparam int SIZE_W = 31;
   localparam int HALF_W = SIZE_W - 1;
   localparam int LIFT_W = 16;

   localparam logic [LIFT_W-1:0] LIFT_RESET = LIFT_W'(6554);

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   // One stored floor box: center and half extents.
   typedef struct packed {
      logic signed [POS_W-1:0] cx;
      logic signed [POS_W-1:0] cy;
      logic signed [POS_W-1:0] cz;
      logic [HALF_W-1:0]       hx;
      logic [HALF_W-1:0]       hy;
      logic [HALF_W-1:0]       hz;
   } floor_type;

   // Query token that walks the cell chain, with the best floor so far.
   typedef struct packed {
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
      logic [HALF_W-1:0]       hx;
      logic [HALF_W-1:0]       hz;
      logic                    found;
      logic signed [POS_W-1:0] best_cy;
      logic [HALF_W-1:0]       best_hy;
   } token_type;

endpackage

/* rtl/hfub_if.sv */
interface hfub_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [3:0]         slot;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [30:0]        size_x;
   logic [30:0]        size_y;
   logic [30:0]        size_z;

   modport source (output valid, command, slot, pos_x, pos_y, pos_z,
                   size_x, size_y, size_z, input ready);
   modport sink   (input valid, command, slot, pos_x, pos_y, pos_z,
                   size_x, size_y, size_z, output ready);
endinterface

interface hfub_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic signed [31:0] shadow_x;
   logic signed [31:0] shadow_y;
   logic signed [31:0] shadow_z;

   modport source (output valid, found, shadow_x, shadow_y, shadow_z, input ready);
   modport sink   (input valid, found, shadow_x, shadow_y, shadow_z, output ready);
endinterface

interface hfub_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

/* rtl/hfub_cell.sv */
module hfub_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  wr_en,
   input  logic                  clr_en,
   input  hfub_pkg::floor_type   wr_floor,
   input  logic                  tok_valid_i,
   input  hfub_pkg::token_type   tok_i,
   output logic                  tok_valid_o,
   output hfub_pkg::token_type   tok_o
);
   import hfub_pkg::*;

   floor_type floor_ff;
   logic      valid_ff;
   logic      valid_in;
   logic      tok_valid_ff;
   token_type tok_ff;
   token_type tok_in;

   logic signed [POS_W+1:0] bx_hi, bx_lo, fx_hi, fx_lo;
   logic signed [POS_W+1:0] bz_hi, bz_lo, fz_hi, fz_lo;
   logic ov_x, ov_z, hit, better;

   // Strict overlap tests in a width where no sum can wrap.
   always_comb begin
      bx_hi = (POS_W+2)'(tok_i.px) + (POS_W+2)'(tok_i.hx);
      bx_lo = (POS_W+2)'(tok_i.px) - (POS_W+2)'(tok_i.hx);
      fx_hi = (POS_W+2)'(floor_ff.cx) + (POS_W+2)'(floor_ff.hx);
      fx_lo = (POS_W+2)'(floor_ff.cx) - (POS_W+2)'(floor_ff.hx);
      bz_hi = (POS_W+2)'(tok_i.pz) + (POS_W+2)'(tok_i.hz);
      bz_lo = (POS_W+2)'(tok_i.pz) - (POS_W+2)'(tok_i.hz);
      fz_hi = (POS_W+2)'(floor_ff.cz) + (POS_W+2)'(floor_ff.hz);
      fz_lo = (POS_W+2)'(floor_ff.cz) - (POS_W+2)'(floor_ff.hz);
      ov_x  = (bx_hi > fx_lo) && (bx_lo < fx_hi);
      ov_z  = (bz_hi > fz_lo) && (bz_lo < fz_hi);
      hit   = valid_ff && ov_x && ov_z && (tok_i.py >= floor_ff.cy);
      // Only a strictly higher floor replaces the best, so lower slots win ties.
      better = hit && (!tok_i.found || (floor_ff.cy > tok_i.best_cy));
      tok_in = tok_i;
      if (better) begin
         tok_in.found   = 1'b1;
         tok_in.best_cy = floor_ff.cy;
         tok_in.best_hy = floor_ff.hy;
      end
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in = 1'b1;
      end else if (clr_en) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (adv) begin
            tok_valid_ff <= tok_valid_i;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         floor_ff <= wr_floor;
      end
      if (adv) begin
         tok_ff <= tok_in;
      end
   end

   assign tok_valid_o = tok_valid_ff;
   assign tok_o       = tok_ff;

endmodule

/* rtl/highest_floor_under_box_core.sv */
// Channel   Direction  Beat contents
// req_chan  in         command, slot, box center pos_x/y/z, full sizes size_x/y/z
// rsp_chan  out        found, shadow_x, shadow_y, shadow_z (one beat per query)
// csr_chan  in         shadow_lift, 16 bits, always ready
//
// A write or clear beat takes effect at its acceptance edge and frees the input
// at once, so such beats can follow each other every cycle while no query is in
// flight. A query walks the row of floor cells, one cell per cycle; the input
// stays not ready until the response is loaded and reopens in that same cycle,
// so the next query is accepted only once the previous response is loaded.
// Reset is synchronous and empties the table.
// A stalled response freezes the walking query in its last cell.
module highest_floor_under_box_core (
   input logic         clock,
   input logic         reset,
   hfub_req_if.sink    req_chan,
   hfub_rsp_if.source  rsp_chan,
   hfub_csr_if.sink    csr_chan
);
   import hfub_pkg::*;

   localparam logic signed [POS_W+1:0] Y_MAX = (POS_W+2)'(64'sd2147483647);
   localparam logic signed [POS_W+1:0] Y_MIN = (POS_W+2)'(-64'sd2147483648);

   logic [LIFT_W-1:0] lift_ff;
   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic signed [POS_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [POS_W-1:0] rsp_y_ff, rsp_y_in;
   logic signed [POS_W-1:0] rsp_z_ff, rsp_z_in;

   logic      req_fire, adv, last_valid, finish;
   cmd_type   cmd;
   floor_type wr_floor;
   logic      tok_valid [NUM_FLOORS+1];
   token_type tok       [NUM_FLOORS+1];
   token_type last_tok;
   logic signed [POS_W+1:0] top_y;

   // The input is open whenever no query is in flight.
   assign req_chan.ready = !busy_ff;
   assign req_fire       = req_chan.valid && !busy_ff;
   assign cmd            = cmd_type'(req_chan.command);
   assign csr_chan.ready = 1'b1;

   assign wr_floor.cx = req_chan.pos_x;
   assign wr_floor.cy = req_chan.pos_y;
   assign wr_floor.cz = req_chan.pos_z;
   assign wr_floor.hx = req_chan.size_x[SIZE_W-1:1];
   assign wr_floor.hy = req_chan.size_y[SIZE_W-1:1];
   assign wr_floor.hz = req_chan.size_z[SIZE_W-1:1];

   // A new query enters the first cell with nothing found yet.
   assign tok_valid[0]   = req_fire && (cmd == CMD_QUERY);
   assign tok[0].px      = req_chan.pos_x;
   assign tok[0].py      = req_chan.pos_y;
   assign tok[0].pz      = req_chan.pos_z;
   assign tok[0].hx      = req_chan.size_x[SIZE_W-1:1];
   assign tok[0].hz      = req_chan.size_z[SIZE_W-1:1];
   assign tok[0].found   = 1'b0;
   assign tok[0].best_cy = '0;
   assign tok[0].best_hy = '0;

   assign last_valid = tok_valid[NUM_FLOORS];
   assign last_tok   = tok[NUM_FLOORS];
   // The chain holds only while a finished query waits on a full output.
   assign adv    = !(last_valid && rsp_valid_ff && !rsp_chan.ready);
   assign finish = last_valid && adv;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_FLOORS; gi++) begin : g_cell
         logic hit_slot;
         assign hit_slot = (32'(req_chan.slot) == 32'(gi));
         hfub_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .adv         (adv),
            .wr_en       (req_fire && (cmd == CMD_WRITE) && hit_slot),
            .clr_en      (req_fire && (cmd == CMD_CLEAR) && hit_slot),
            .wr_floor    (wr_floor),
            .tok_valid_i (tok_valid[gi]),
            .tok_i       (tok[gi]),
            .tok_valid_o (tok_valid[gi+1]),
            .tok_o       (tok[gi+1])
         );
      end
   endgenerate

   // Floor top plus lift, then clamp to the signed 32-bit range.
   always_comb begin
      top_y = (POS_W+2)'(last_tok.best_cy) + (POS_W+2)'(last_tok.best_hy)
              + (POS_W+2)'(lift_ff);
      rsp_found_in = rsp_found_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_valid_in = rsp_valid_ff;
      busy_in      = busy_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         busy_in      = 1'b0;
         rsp_found_in = last_tok.found;
         if (last_tok.found) begin
            rsp_x_in = last_tok.px;
            rsp_z_in = last_tok.pz;
            if (top_y > Y_MAX) begin
               rsp_y_in = Y_MAX[POS_W-1:0];
            end else if (top_y < Y_MIN) begin
               rsp_y_in = Y_MIN[POS_W-1:0];
            end else begin
               rsp_y_in = top_y[POS_W-1:0];
            end
         end else begin
            rsp_x_in = '0;
            rsp_y_in = '0;
            rsp_z_in = '0;
         end
      end
      if (tok_valid[0]) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lift_ff      <= LIFT_RESET;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            lift_ff <= csr_chan.data;
         end
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.found    = rsp_found_ff;
   assign rsp_chan.shadow_x = rsp_x_ff;
   assign rsp_chan.shadow_y = rsp_y_ff;
   assign rsp_chan.shadow_z = rsp_z_ff;

endmodule

/* rtl/hfub_checker.sv */
module hfub_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [31:0] rsp_shadow_x,
   input logic [31:0] rsp_shadow_y,
   input logic [31:0] rsp_shadow_z
);
   import hfub_pkg::*;

   // An accepted query keeps the input closed while it walks the chain.
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_QUERY) |=> !req_ready)
      else $error("input stayed open after a query was accepted");

   // A miss reports all coordinates as zero.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |->
         (rsp_shadow_x == '0) && (rsp_shadow_y == '0) && (rsp_shadow_z == '0))
      else $error("miss response carries nonzero coordinates");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_shadow_x)
         && $stable(rsp_shadow_y) && $stable(rsp_shadow_z))
      else $error("response changed while stalled");

endmodule

bind highest_floor_under_box_core hfub_checker u_hfub_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .req_command  (req_chan.command),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .rsp_found    (rsp_chan.found),
   .rsp_shadow_x (rsp_chan.shadow_x),
   .rsp_shadow_y (rsp_chan.shadow_y),
   .rsp_shadow_z (rsp_chan.shadow_z)
);
